// ----- src/ipa_pkg.sv -----
`default_nettype none

package ipa_pkg;

    // Vertex payload: pos_xy, pos_z, normal_xy, normal_z, color_rg, color_ba.
    localparam int VtxW      = 320;
    localparam int UserInW   = 6;
    localparam int UserOutW  = 4;
    localparam int PrimW     = 4;
    localparam int DrawW     = 3;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    // Three corners of a quad are held until the fourth arrives.
    localparam int QuadHeld = 3;

    typedef enum logic [1:0] {
        EV_BEGIN  = 2'd0,
        EV_VERTEX = 2'd1,
        EV_END    = 2'd2
    } t_event;

    localparam logic [PrimW-1:0] PRIM_LINE_LOOP  = 4'd2;
    localparam logic [PrimW-1:0] PRIM_LINE_STRIP = 4'd3;
    localparam logic [PrimW-1:0] PRIM_TRIANGLES  = 4'd4;
    localparam logic [PrimW-1:0] PRIM_TRI_STRIP  = 4'd5;
    localparam logic [PrimW-1:0] PRIM_TRI_FAN    = 4'd6;
    localparam logic [PrimW-1:0] PRIM_QUADS      = 4'd7;
    localparam logic [PrimW-1:0] PRIM_QUAD_STRIP = 4'd8;
    localparam logic [PrimW-1:0] PRIM_POLYGON    = 4'd9;

    localparam logic [1:0] QUAD_LAST_SLOT = 2'd3;

    // Commands handed from the front end to the output sequencer.
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,  // store vertex in held slot, no output
        OP_EMIT      = 3'd1,  // send vertex
        OP_EMIT_KEEP = 3'd2,  // send vertex and keep it as loop start
        OP_QUAD      = 3'd3,  // send two triangles of a finished quad
        OP_LOOP_END  = 3'd4,  // resend loop start, then end marker
        OP_MARKER    = 3'd5   // end marker only
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [1:0]        slot;
        logic [DrawW-1:0]  dmode;
        logic [VtxW-1:0]   vtx;
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/ipa_front.sv -----
`default_nettype none

module ipa_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [ipa_pkg::UserInW-1:0] i_user,
    input  wire logic [ipa_pkg::VtxW-1:0]    i_data,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output ipa_pkg::t_cmd                    o_cmd
);
    import ipa_pkg::*;

    logic             r_active, n_active;
    logic [PrimW-1:0] r_prim,   n_prim;
    logic             r_any,    n_any;
    logic [1:0]       r_slot,   n_slot;

    logic             accept;
    logic [PrimW-1:0] req;
    logic             supported;

    // Primitives the downstream pipe cannot draw are renumbered.
    function automatic logic [DrawW-1:0] map_mode(input logic [PrimW-1:0] t);
        logic [PrimW-1:0] m;
        begin
            m = t;
            if (t == PRIM_QUADS) m = PRIM_TRIANGLES;
            else if (t == PRIM_QUAD_STRIP) m = PRIM_TRI_STRIP;
            else if (t == PRIM_LINE_LOOP) m = PRIM_LINE_STRIP;
            else if (t == PRIM_POLYGON) m = PRIM_TRI_FAN;
            return m[DrawW-1:0];
        end
    endfunction

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign req       = i_user[UserInW-1:2];
    assign supported = (r_prim <= PRIM_POLYGON);

    always_comb begin
        n_active    = r_active;
        n_prim      = r_prim;
        n_any       = r_any;
        n_slot      = r_slot;
        o_push      = 1'b0;
        o_cmd.op    = OP_EMIT;
        o_cmd.slot  = r_slot;
        o_cmd.dmode = map_mode(r_prim);
        o_cmd.vtx   = i_data;
        if (accept) begin
            unique case (t_event'(i_user[1:0]))
                EV_BEGIN: begin
                    if (!r_active) begin
                        n_prim   = req;
                        n_active = 1'b1;
                        n_any    = 1'b0;
                        n_slot   = 2'd0;
                    end
                end
                EV_VERTEX: begin
                    if (r_active && supported) begin
                        o_push = 1'b1;
                        n_any  = 1'b1;
                        if (r_prim == PRIM_QUADS) begin
                            if (r_slot != QUAD_LAST_SLOT) begin
                                o_cmd.op = OP_HOLD;
                                n_slot   = r_slot + 2'd1;
                            end else begin
                                o_cmd.op = OP_QUAD;
                                n_slot   = 2'd0;
                            end
                        end else if (r_prim == PRIM_LINE_LOOP && !r_any) begin
                            o_cmd.op = OP_EMIT_KEEP;
                        end
                    end
                end
                EV_END: begin
                    if (r_active) begin
                        n_active = 1'b0;
                        n_slot   = 2'd0;
                        if (r_any && supported) begin
                            o_push   = 1'b1;
                            o_cmd.op = (r_prim == PRIM_LINE_LOOP) ? OP_LOOP_END : OP_MARKER;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_prim   <= '0;
            r_any    <= 1'b0;
            r_slot   <= 2'd0;
        end else begin
            r_active <= n_active;
            r_prim   <= n_prim;
            r_any    <= n_any;
            r_slot   <= n_slot;
        end
    end

endmodule

`default_nettype wire

// ----- src/ipa_queue.sv -----
`default_nettype none

module ipa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ipa_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output ipa_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import ipa_pkg::*;

    t_cmd             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [QPtrW:0]   r_count;

    assign o_full  = (r_count == QueueDepth[QPtrW:0]);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPtrW'(1);
            if (i_pop)  r_rptr <= r_rptr + QPtrW'(1);
            if (i_push && !i_pop)      r_count <= r_count + (QPtrW+1)'(1);
            else if (i_pop && !i_push) r_count <= r_count - (QPtrW+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/ipa_back.sv -----
`default_nettype none

module ipa_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire ipa_pkg::t_cmd                i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [ipa_pkg::VtxW-1:0]          o_data,
    output logic [ipa_pkg::UserOutW-1:0]      o_user,
    output logic                              o_last
);
    import ipa_pkg::*;

    logic [VtxW-1:0] r_held [QuadHeld];
    logic [2:0]      r_step;
    logic            r_ovalid;
    logic [VtxW-1:0] r_odata;
    logic [UserOutW-1:0] r_ouser;
    logic            r_olast;

    logic            has_out;
    logic            is_last;
    logic            is_marker;
    logic [VtxW-1:0] src_vtx;
    logic            out_free;
    logic            fire;

    // Output pattern of each command, one result per step; a hold command gives none.
    always_comb begin
        has_out   = 1'b1;
        is_last   = 1'b1;
        is_marker = 1'b0;
        src_vtx   = i_cmd.vtx;
        unique case (i_cmd.op)
            OP_HOLD: begin
                has_out = 1'b0;
            end
            OP_EMIT, OP_EMIT_KEEP: begin
            end
            OP_QUAD: begin
                is_last = 1'b0;
                unique case (r_step)
                    3'd0: src_vtx = r_held[0];
                    3'd1: src_vtx = r_held[1];
                    3'd2: src_vtx = r_held[2];
                    3'd3: src_vtx = r_held[0];
                    3'd4: src_vtx = r_held[2];
                    default: is_last = 1'b1;
                endcase
            end
            OP_LOOP_END: begin
                if (r_step == 3'd0) begin
                    src_vtx = r_held[0];
                    is_last = 1'b0;
                end else begin
                    is_marker = 1'b1;
                end
            end
            OP_MARKER: begin
                is_marker = 1'b1;
            end
            default: begin
                has_out = 1'b0;
            end
        endcase
    end

    assign out_free = !r_ovalid || i_ready;
    assign fire     = i_q_valid && (!has_out || out_free);
    assign o_pop    = fire && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_step   <= 3'd0;
        end else begin
            if (fire && has_out) r_ovalid <= 1'b1;
            else if (i_ready)    r_ovalid <= 1'b0;
            if (fire) r_step <= is_last ? 3'd0 : r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_out) begin
            r_odata <= is_marker ? '0 : src_vtx;
            r_ouser <= {i_cmd.dmode, is_marker};
            r_olast <= is_last;
        end
        if (fire && i_cmd.op == OP_HOLD) begin
            r_held[i_cmd.slot] <= i_cmd.vtx;
        end else if (fire && i_cmd.op == OP_EMIT_KEEP) begin
            r_held[0] <= i_cmd.vtx;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

// ----- src/immediate_primitive_assembler_top.sv -----
`default_nettype none

// Channel   Direction  Carries
// s_axis    in         begin / vertex / end events, one per transaction
// m_axis    out        vertices of the redrawn primitive and end-of-draw markers
//
// Input transactions are accepted one per cycle while the four-entry command queue
// has room; a command is queued and its result held in the output register.
// Results leave one per cycle while m_axis_tready is high; a quad's fourth vertex
// expands into six results and a line loop end into two; a run of quads can fill the queue
// even with m_axis always ready, and an m_axis stall backs up to s_axis_tready.
// Reset is synchronous and active low; held vertices stay undefined until written.
module immediate_primitive_assembler_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: pos_xy, pos_z, normal_xy, normal_z, color_rg, color_ba.
    input  wire logic [ipa_pkg::VtxW-1:0]     s_axis_tdata,
    // Fields from bit 0: mode (2 bits), primitive_req (4 bits).
    input  wire logic [ipa_pkg::UserInW-1:0]  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // Fields from bit 0: out_pos_xy, out_pos_z, out_normal_xy, out_normal_z,
    // out_color_rg, out_color_ba.
    output logic [ipa_pkg::VtxW-1:0]          m_axis_tdata,
    // Fields from bit 0: kind (1 bit), draw_mode (3 bits).
    output logic [ipa_pkg::UserOutW-1:0]      m_axis_tuser,
    // Marks the final result caused by one input transaction.
    output logic                              m_axis_tlast
);
    import ipa_pkg::*;

    logic q_push;
    t_cmd q_in;
    logic q_full;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    // The front end tracks the begin/end state and decides which command,
    // if any, each event turns into.
    ipa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_user   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    ipa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    // The sequencer holds quad corners and the loop start vertex, and expands
    // each command into its results.
    ipa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    // An end-of-draw marker is always the final result of its event.
    a_marker_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("end marker without tlast");

    // A marker carries no vertex words.
    a_marker_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("end marker with vertex data");

    // Only drawable primitives leave the block.
    a_draw_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[UserOutW-1:1] != 3'd7))
        else $error("unmapped draw mode on output");

    // Reset empties the output register.
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
